// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PML_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pose motion limit checker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PML_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pose motion limit checker assertion failed");

`endif

// ===== sv/pml_pkg.sv =====
// Types and constants shared by the pose motion limit checker modules.
`default_nettype none

package pml_pkg;

    localparam int POS_WIDTH_DEF = 32;
    localparam int VEL_WIDTH_DEF = 48;
    localparam int TIME_W        = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int NS_W          = 30;
    localparam int ACC_CAP_LOG2  = 41;
    localparam int LIM_W         = 40;
    localparam int STEP_W        = 32;

    localparam logic [NS_W-1:0] NS_PER_S = 30'd1000000000;

    localparam logic [CFG_IDX_W-1:0] CFG_X_BOUNDS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_BOUNDS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_BOUNDS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL = 3'd5;

    localparam logic [1:0] LIMB_RIGHT = 2'd0;
    localparam logic [1:0] LIMB_HEAD  = 2'd2;
    localparam logic [1:0] LIMB_NONE  = 2'd3;

    localparam logic KIND_CLEAR = 1'b1;

    typedef enum logic [0:0] {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_WORKSPACE = 3'd1,
        STAT_ZERO_TIME = 3'd2,
        STAT_TIME_BACK = 3'd3,
        STAT_STEP      = 3'd4,
        STAT_SPEED     = 3'd5,
        STAT_ACCEL     = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_STEP_MUL,
        S_STEP_LIM,
        S_VEL_MUL,
        S_VEL_DIV,
        S_VEL_SQ,
        S_SPD_LIM,
        S_ACC_MUL,
        S_ACC_DIV,
        S_ACC_SQ,
        S_ACC_LIM,
        S_STAGE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/pml_alu.sv =====
// Shared iterative unit: shift-add multiplier and restoring divider, one bit per cycle.
`default_nettype none

module pml_alu
    import pml_pkg::*;
#(
    parameter int OPW  = 48,
    parameter int NUMW = 78
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_alu_req          i_req,
    input  wire logic [OPW-1:0]    i_mul_a,
    input  wire logic [OPW-1:0]    i_mul_b,
    input  wire logic [NUMW-1:0]   i_num,
    input  wire logic [TIME_W-1:0] i_den,
    output logic                   o_busy,
    output logic [2*OPW-1:0]       o_result
);

    localparam int STEPS = (NUMW > OPW) ? NUMW : OPW;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic              r_busy;
    t_alu_op           r_op;
    logic [CNT_W-1:0]  r_cnt;
    logic [2*OPW-1:0]  r_acc;
    logic [2*OPW-1:0]  r_mcand;
    logic [OPW-1:0]    r_mplier;
    logic [TIME_W-1:0] r_rem;
    logic [NUMW-1:0]   r_quo;
    logic [TIME_W-1:0] r_den;

    logic [TIME_W:0]   div_shift;
    logic [TIME_W+1:0] div_diff;
    logic              div_ge;

    // The remainder stays below the divisor, so one extra bit holds the shifted value.
    assign div_shift = {r_rem, r_quo[NUMW-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, r_den};
    assign div_ge    = !div_diff[TIME_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_op   <= ALU_MUL;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_op   <= i_req.op;
            r_cnt  <= (i_req.op == ALU_MUL) ? CNT_W'(OPW) : CNT_W'(NUMW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc    <= '0;
            r_mcand  <= {{OPW{1'b0}}, i_mul_a};
            r_mplier <= i_mul_b;
            r_rem    <= '0;
            r_quo    <= i_num;
            r_den    <= i_den;
        end else if (r_busy) begin
            if (r_op == ALU_MUL) begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[2*OPW-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[OPW-1:1]};
            end else begin
                r_rem <= div_ge ? div_diff[TIME_W-1:0] : div_shift[TIME_W-1:0];
                r_quo <= {r_quo[NUMW-2:0], div_ge};
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_result = (r_op == ALU_MUL) ? r_acc : {{(2*OPW-NUMW){1'b0}}, r_quo};

    `include "assert_macros.svh"

    `PML_ASSERT_IMP(a_alu_no_restart, i_clk, i_rst_n, r_busy, !i_req.start)
    `PML_ASSERT_IMP(a_alu_count_live, i_clk, i_rst_n, r_busy, r_cnt != '0)
    `PML_ASSERT_NXT(a_alu_start_busy, i_clk, i_rst_n, i_req.start, r_busy)

endmodule

`default_nettype wire

// ===== sv/pose_motion_limit_checker.sv =====
// Top level of the pose motion limit checker: sequencer, limb histories and result register.
`default_nettype none

// Channel   Direction  Handshake               Payload
// input     in         i_in_valid / o_in_stall i_kind .. i_clear_mask
// output    out        o_out_valid/i_out_stall o_status, o_failed_limb
// config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
// A pose item is worked on by one shared multiply/divide unit that retires one bit per
// cycle; each operation is issued and its result taken before the next one starts. The
// step, speed and acceleration checks run in that order on a fully checked pose; a first
// pose, an invalid pose, a pose in a frame that already failed, or a pose that fails the
// workspace or time checks goes from the check step straight to the final step. Clear
// items and limb-three items are absorbed in the transfer cycle itself. Reset is
// synchronous and clears flags, control and the limit registers; no clearing pass is
// needed. A stalled result holds the sequencer in its final step until the result
// transfer completes.

module pose_motion_limit_checker
    import pml_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF,
    parameter int VEL_WIDTH = VEL_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_kind,
    input  wire logic [1:0]            i_limb,
    input  wire logic                  i_pose_valid,
    input  wire logic                  i_present,
    input  wire logic signed [31:0]    i_pos_x,
    input  wire logic signed [31:0]    i_pos_y,
    input  wire logic signed [31:0]    i_pos_z,
    input  wire logic [63:0]           i_timestamp_ns,
    input  wire logic [2:0]            i_clear_mask,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [2:0]                 o_status,
    output logic [1:0]                 o_failed_limb,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Operand width of the shared unit covers velocities, the 40-bit limits and the
    // acceleration cap; the dividend is a velocity-sized value times one billion.
    localparam int OPW  = (VEL_WIDTH > ACC_CAP_LOG2 + 1) ? VEL_WIDTH : ACC_CAP_LOG2 + 1;
    localparam int NUMW = VEL_WIDTH + NS_W;
    localparam int SUMW = 2 * OPW + 2;
    localparam int PW   = POS_WIDTH;
    localparam int VW   = VEL_WIDTH;

    localparam logic [NUMW-1:0] ONE_N   = {{(NUMW-1){1'b0}}, 1'b1};
    localparam logic [NUMW-1:0] VEL_LIM = ONE_N << (VW - 1);
    localparam logic [NUMW-1:0] ACC_CAP = ONE_N << ACC_CAP_LOG2;

    // Configuration registers.
    logic [63:0]       r_x_bounds, r_y_bounds, r_z_bounds;
    logic [STEP_W-1:0] r_max_step;
    logic [LIM_W-1:0]  r_max_speed, r_max_accel;

    // Committed limb histories; entries are read only while their flag is set.
    logic [1:0]           r_trk_flags [3];
    logic signed [PW-1:0] r_trk_pos   [3][3];
    logic [TIME_W-1:0]    r_trk_time  [3];
    logic signed [VW-1:0] r_trk_vel   [3][3];

    // Staged updates of the frame in progress.
    logic [2:0]           r_stg_flags [3];
    logic signed [PW-1:0] r_stg_pos   [3][3];
    logic [TIME_W-1:0]    r_stg_time  [3];
    logic signed [VW-1:0] r_stg_vel   [3][3];

    t_status    r_frm_status;
    logic [1:0] r_frm_limb;

    // Item under work.
    logic [1:0]           r_limb;
    logic                 r_pose_valid;
    logic                 r_present;
    logic signed [PW-1:0] r_pos [3];
    logic [TIME_W-1:0]    r_time;

    // Sequencer working registers.
    t_state               r_state, n_state;
    logic                 r_issued;
    logic [1:0]           r_axis;
    logic [TIME_W-1:0]    r_dt;
    logic [SUMW-1:0]      r_sum;
    logic [NUMW-1:0]      r_num;
    logic [OPW-1:0]       r_q;
    logic signed [VW-1:0] r_vel [3];

    logic       r_out_valid;
    t_status    r_out_status;
    logic [1:0] r_out_limb;

    // Shared unit connections.
    t_alu_req         alu_req;
    logic [OPW-1:0]   alu_a, alu_b;
    logic             alu_busy;
    logic [2*OPW-1:0] alu_result;
    logic             alu_state;
    logic             alu_done;

    logic             in_xfer;
    logic             out_free;
    logic signed [PW:0] pos_diff;
    logic             d_neg;
    logic [PW:0]      d_mag;
    logic signed [VW:0] v_diff;
    logic [VW-1:0]    acc_mag;
    logic [NUMW-1:0]  quo;
    logic [NUMW-1:0]  vel_sat;
    logic [NUMW-1:0]  acc_sat;
    logic signed [VW-1:0] vel_new;
    logic [SUMW-1:0]  sum_next;
    logic             over_lim;
    logic             box_ok;
    t_status          chk_code;
    logic             chk_first;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign alu_done = r_issued && !alu_busy;

    pml_alu #(
        .OPW  (OPW),
        .NUMW (NUMW)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_mul_a  (alu_a),
        .i_mul_b  (alu_b),
        .i_num    (r_num),
        .i_den    (r_dt),
        .o_busy   (alu_busy),
        .o_result (alu_result)
    );

    // Per-axis values of the current limb.
    always_comb begin
        pos_diff = {r_pos[r_axis][PW-1], r_pos[r_axis]}
                 - {r_trk_pos[r_limb][r_axis][PW-1], r_trk_pos[r_limb][r_axis]};
        d_neg    = pos_diff[PW];
        d_mag    = d_neg ? (PW+1)'(-pos_diff) : pos_diff;
        v_diff   = {r_vel[r_axis][VW-1], r_vel[r_axis]}
                 - {r_trk_vel[r_limb][r_axis][VW-1], r_trk_vel[r_limb][r_axis]};
        acc_mag  = v_diff[VW] ? VW'(-v_diff) : v_diff[VW-1:0];
        quo      = alu_result[NUMW-1:0];
        if (d_neg) begin
            vel_sat = (quo > VEL_LIM) ? VEL_LIM : quo;
            vel_new = -signed'(vel_sat[VW-1:0]);
        end else begin
            vel_sat = (quo > VEL_LIM - ONE_N) ? VEL_LIM - ONE_N : quo;
            vel_new = signed'(vel_sat[VW-1:0]);
        end
        acc_sat  = (quo > ACC_CAP) ? ACC_CAP : quo;
        sum_next = r_sum + {2'b00, alu_result};
        over_lim = r_sum > {2'b00, alu_result};
    end

    // Workspace, time and first-pose checks of one item.
    always_comb begin
        box_ok = r_present
            && r_pos[0] >= signed'(r_x_bounds[PW-1:0])
            && r_pos[0] <= signed'(r_x_bounds[32+PW-1:32])
            && r_pos[1] >= signed'(r_y_bounds[PW-1:0])
            && r_pos[1] <= signed'(r_y_bounds[32+PW-1:32])
            && r_pos[2] >= signed'(r_z_bounds[PW-1:0])
            && r_pos[2] <= signed'(r_z_bounds[32+PW-1:32]);
        chk_first = 1'b0;
        if (!box_ok) begin
            chk_code = STAT_WORKSPACE;
        end else if (r_time == '0) begin
            chk_code = STAT_ZERO_TIME;
        end else if (!r_trk_flags[r_limb][0]) begin
            chk_code  = STAT_OK;
            chk_first = 1'b1;
        end else if (r_time <= r_trk_time[r_limb]) begin
            chk_code = STAT_TIME_BACK;
        end else begin
            chk_code = STAT_OK;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && i_kind != KIND_CLEAR && i_limb != LIMB_NONE) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_frm_status != STAT_OK || !r_pose_valid || chk_code != STAT_OK
                        || chk_first) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_STEP_MUL;
                end
            end
            S_STEP_MUL: if (alu_done && r_axis == 2'd2) n_state = S_STEP_LIM;
            S_STEP_LIM: if (alu_done) n_state = over_lim ? S_DONE : S_VEL_MUL;
            S_VEL_MUL:  if (alu_done) n_state = S_VEL_DIV;
            S_VEL_DIV:  if (alu_done) n_state = S_VEL_SQ;
            S_VEL_SQ: begin
                if (alu_done) n_state = (r_axis == 2'd2) ? S_SPD_LIM : S_VEL_MUL;
            end
            S_SPD_LIM: begin
                if (alu_done) begin
                    if (over_lim) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = r_trk_flags[r_limb][1] ? S_ACC_MUL : S_STAGE;
                    end
                end
            end
            S_ACC_MUL: if (alu_done) n_state = S_ACC_DIV;
            S_ACC_DIV: if (alu_done) n_state = S_ACC_SQ;
            S_ACC_SQ: begin
                if (alu_done) n_state = (r_axis == 2'd2) ? S_ACC_LIM : S_ACC_MUL;
            end
            S_ACC_LIM: if (alu_done) n_state = over_lim ? S_DONE : S_STAGE;
            S_STAGE:   n_state = S_DONE;
            S_DONE: begin
                if (r_limb != LIMB_HEAD || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: the shared unit's request and operands, and the input stall.
    always_comb begin
        alu_state  = 1'b0;
        alu_req.op = ALU_MUL;
        alu_a      = '0;
        alu_b      = '0;
        unique case (r_state)
            S_STEP_MUL: begin
                alu_state = 1'b1;
                alu_a     = OPW'(d_mag);
                alu_b     = OPW'(d_mag);
            end
            S_STEP_LIM: begin
                alu_state = 1'b1;
                alu_a     = OPW'(r_max_step);
                alu_b     = OPW'(r_max_step);
            end
            S_VEL_MUL: begin
                alu_state = 1'b1;
                alu_a     = OPW'(d_mag);
                alu_b     = OPW'(NS_PER_S);
            end
            S_VEL_DIV, S_ACC_DIV: begin
                alu_state  = 1'b1;
                alu_req.op = ALU_DIV;
            end
            S_VEL_SQ, S_ACC_SQ: begin
                alu_state = 1'b1;
                alu_a     = r_q;
                alu_b     = r_q;
            end
            S_SPD_LIM: begin
                alu_state = 1'b1;
                alu_a     = OPW'(r_max_speed);
                alu_b     = OPW'(r_max_speed);
            end
            S_ACC_MUL: begin
                alu_state = 1'b1;
                alu_a     = OPW'(acc_mag);
                alu_b     = OPW'(NS_PER_S);
            end
            S_ACC_LIM: begin
                alu_state = 1'b1;
                alu_a     = OPW'(r_max_accel);
                alu_b     = OPW'(r_max_accel);
            end
            default: begin
                alu_state = 1'b0;
            end
        endcase
        alu_req.start = alu_state && !r_issued;
        o_in_stall    = (r_state != S_IDLE);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_issued     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_frm_status <= STAT_OK;
            r_frm_limb   <= LIMB_NONE;
            r_x_bounds   <= '0;
            r_y_bounds   <= '0;
            r_z_bounds   <= '0;
            r_max_step   <= '0;
            r_max_speed  <= '0;
            r_max_accel  <= '0;
            for (int l = 0; l < 3; l++) begin
                r_trk_flags[l] <= '0;
                r_stg_flags[l] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (alu_req.start) begin
                r_issued <= 1'b1;
            end else if (alu_done) begin
                r_issued <= 1'b0;
            end

            // The head item loads a new result once the old one has left.
            if (r_state == S_DONE && r_limb == LIMB_HEAD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_X_BOUNDS:  r_x_bounds  <= i_cfg_data;
                    CFG_Y_BOUNDS:  r_y_bounds  <= i_cfg_data;
                    CFG_Z_BOUNDS:  r_z_bounds  <= i_cfg_data;
                    CFG_MAX_STEP:  r_max_step  <= i_cfg_data[STEP_W-1:0];
                    CFG_MAX_SPEED: r_max_speed <= i_cfg_data[LIM_W-1:0];
                    CFG_MAX_ACCEL: r_max_accel <= i_cfg_data[LIM_W-1:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        // A clear item or a right-arm pose opens a fresh frame.
                        if (i_kind == KIND_CLEAR || i_limb == LIMB_RIGHT) begin
                            r_frm_status <= STAT_OK;
                            r_frm_limb   <= LIMB_NONE;
                            for (int l = 0; l < 3; l++) begin
                                r_stg_flags[l] <= '0;
                            end
                        end
                        if (i_kind == KIND_CLEAR) begin
                            for (int l = 0; l < 3; l++) begin
                                if (i_clear_mask[l]) begin
                                    r_trk_flags[l] <= '0;
                                end
                            end
                        end
                    end
                end
                S_CHECK: begin
                    if (r_frm_status == STAT_OK) begin
                        if (r_pose_valid && chk_code != STAT_OK) begin
                            r_frm_status <= chk_code;
                            r_frm_limb   <= r_limb;
                        end
                        r_stg_flags[r_limb] <= (r_pose_valid && chk_first) ? 3'b011 : 3'b000;
                    end
                end
                S_STEP_LIM: begin
                    if (alu_done && over_lim) begin
                        r_frm_status <= STAT_STEP;
                        r_frm_limb   <= r_limb;
                    end
                end
                S_SPD_LIM: begin
                    if (alu_done && over_lim) begin
                        r_frm_status <= STAT_SPEED;
                        r_frm_limb   <= r_limb;
                    end
                end
                S_ACC_LIM: begin
                    if (alu_done && over_lim) begin
                        r_frm_status <= STAT_ACCEL;
                        r_frm_limb   <= r_limb;
                    end
                end
                S_STAGE: begin
                    r_stg_flags[r_limb] <= 3'b111;
                end
                S_DONE: begin
                    // The head item closes the frame: report, commit on success, restart.
                    if (r_limb == LIMB_HEAD && out_free) begin
                        if (r_frm_status == STAT_OK) begin
                            for (int l = 0; l < 3; l++) begin
                                if (r_stg_flags[l][0]) begin
                                    r_trk_flags[l] <= r_stg_flags[l][2:1];
                                end
                            end
                        end
                        r_frm_status <= STAT_OK;
                        r_frm_limb   <= LIMB_NONE;
                        for (int l = 0; l < 3; l++) begin
                            r_stg_flags[l] <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers; they are only read under the flags above.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_xfer) begin
            r_limb       <= i_limb;
            r_pose_valid <= i_pose_valid;
            r_present    <= i_present;
            r_pos[0]     <= signed'(i_pos_x[PW-1:0]);
            r_pos[1]     <= signed'(i_pos_y[PW-1:0]);
            r_pos[2]     <= signed'(i_pos_z[PW-1:0]);
            r_time       <= i_timestamp_ns;
        end

        if (i_kind == KIND_CLEAR && r_state == S_IDLE && in_xfer) begin
            for (int l = 0; l < 3; l++) begin
                if (i_clear_mask[l]) begin
                    r_trk_time[l] <= '0;
                    for (int a = 0; a < 3; a++) begin
                        r_trk_pos[l][a] <= '0;
                        r_trk_vel[l][a] <= '0;
                    end
                end
            end
        end

        unique case (r_state)
            S_CHECK: begin
                r_axis <= 2'd0;
                r_sum  <= '0;
                r_dt   <= r_time - r_trk_time[r_limb];
                if (chk_first) begin
                    r_stg_time[r_limb] <= r_time;
                    for (int a = 0; a < 3; a++) begin
                        r_stg_pos[r_limb][a] <= r_pos[a];
                        r_stg_vel[r_limb][a] <= '0;
                    end
                end
            end
            S_STEP_MUL, S_VEL_SQ, S_ACC_SQ: begin
                if (alu_done) begin
                    r_sum  <= sum_next;
                    r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                end
            end
            S_STEP_LIM, S_SPD_LIM: begin
                if (alu_done) begin
                    r_sum  <= '0;
                    r_axis <= 2'd0;
                end
            end
            S_VEL_MUL, S_ACC_MUL: begin
                if (alu_done) begin
                    r_num <= alu_result[NUMW-1:0];
                end
            end
            S_VEL_DIV: begin
                if (alu_done) begin
                    r_q           <= vel_sat[OPW-1:0];
                    r_vel[r_axis] <= vel_new;
                end
            end
            S_ACC_DIV: begin
                if (alu_done) begin
                    r_q <= acc_sat[OPW-1:0];
                end
            end
            S_STAGE: begin
                r_stg_time[r_limb] <= r_time;
                for (int a = 0; a < 3; a++) begin
                    r_stg_pos[r_limb][a] <= r_pos[a];
                    r_stg_vel[r_limb][a] <= r_vel[a];
                end
            end
            S_DONE: begin
                if (r_limb == LIMB_HEAD && out_free) begin
                    r_out_status <= r_frm_status;
                    r_out_limb   <= (r_frm_status == STAT_OK) ? LIMB_NONE : r_frm_limb;
                    if (r_frm_status == STAT_OK) begin
                        for (int l = 0; l < 3; l++) begin
                            if (r_stg_flags[l][0]) begin
                                r_trk_time[l] <= r_stg_time[l];
                                for (int a = 0; a < 3; a++) begin
                                    r_trk_pos[l][a] <= r_stg_pos[l][a];
                                    r_trk_vel[l][a] <= r_stg_vel[l][a];
                                end
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_failed_limb = r_out_limb;

    `include "assert_macros.svh"

    `PML_ASSERT_IMP(a_fail_names_limb, i_clk, i_rst_n, r_frm_status != STAT_OK, r_frm_limb != LIMB_NONE)
    `PML_ASSERT_IMP(a_ok_has_no_limb, i_clk, i_rst_n, o_out_valid && o_status == STAT_OK, o_failed_limb == LIMB_NONE)
    `PML_ASSERT_IMP(a_result_after_head, i_clk, i_rst_n, $rose(o_out_valid), r_limb == LIMB_HEAD)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the pose motion limit checker: directed table, then random frames.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pml_pkg::*;

    // One input transfer, laid out as the block's input fields.
    typedef struct packed {
        logic               kind;
        logic [1:0]         limb;
        logic               pose_valid;
        logic               present;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [63:0]        timestamp_ns;
        logic [2:0]         clear_mask;
    } t_pose_item;

    // One frame verdict, as the block reports it on its output.
    typedef struct packed {
        t_status    status;
        logic [1:0] limb;
    } t_verdict;

    // A row of the directed table: either a full register setting or one item.
    typedef struct {
        bit          is_cfg;
        logic [63:0] cfg[6];
        t_pose_item  item;
        bit          typed;
        t_verdict    verdict;
    } t_stim_row;

    localparam logic [CFG_IDX_W-1:0] REG_INDEX[6] = '{CFG_X_BOUNDS, CFG_Y_BOUNDS,
        CFG_Z_BOUNDS, CFG_MAX_STEP, CFG_MAX_SPEED, CFG_MAX_ACCEL};
    localparam logic [63:0] FULL_BOX  = 64'h7FFF_FFFF_8000_0000;
    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ACC_LIMIT = 64'd1 << ACC_CAP_LOG2;
    localparam logic [63:0] VEL_LIMIT = 64'd1 << (VEL_WIDTH_DEF - 1);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_pose_item            drv;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [2:0]            o_status;
    logic [1:0]            o_failed_limb;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pose_motion_limit_checker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (drv.kind),
        .i_limb         (drv.limb),
        .i_pose_valid   (drv.pose_valid),
        .i_present      (drv.present),
        .i_pos_x        (drv.pos_x),
        .i_pos_y        (drv.pos_y),
        .i_pos_z        (drv.pos_z),
        .i_timestamp_ns (drv.timestamp_ns),
        .i_clear_mask   (drv.clear_mask),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_failed_limb  (o_failed_limb),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Shadow copy of the block's limits and limb histories.
    logic [63:0] box_x, box_y, box_z;
    logic [31:0] lim_step;
    logic [39:0] lim_speed, lim_accel;

    logic [1:0]  trk_flags[3];
    longint      trk_pos[9];
    logic [63:0] trk_time[3];
    longint      trk_vel[9];
    logic [2:0]  stg_flags[3];
    longint      stg_pos[9];
    logic [63:0] stg_time[3];
    longint      stg_vel[9];
    t_status     frm_status;
    logic [1:0]  frm_limb;

    t_verdict    verdicts_due[$];
    int          fail_count = 0;
    int          burst_left = 0;
    bit          hold_off_req = 0;
    logic [63:0] t_now;
    t_stim_row   stim_table[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs somewhere.
    initial begin
        #200ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void wipe_limb(int l);
        trk_flags[l] = '0;
        trk_time[l]  = '0;
        for (int a = 0; a < 3; a++) begin
            trk_pos[l*3+a] = 0;
            trk_vel[l*3+a] = 0;
        end
    endfunction

    function automatic void open_frame();
        for (int l = 0; l < 3; l++) stg_flags[l] = '0;
        frm_status = STAT_OK;
        frm_limb   = LIMB_NONE;
    endfunction

    // Each box register packs a signed minimum in the low half and a maximum in the high half.
    function automatic bit in_box(longint p, logic [63:0] b);
        int lo, hi;
        lo = b[31:0];
        hi = b[63:32];
        return p >= lo && p <= hi;
    endfunction

    // Runs the checks for one pose against the limb's committed history and stages it if it passes.
    function automatic t_status judge_pose(int l, t_pose_item it);
        longint       p[3], v[3];
        longint       d, pv;
        logic [63:0]  dt, mg, q, am;
        logic [127:0] sum, qa;
        stg_flags[l] = '0;
        if (!it.pose_valid) return STAT_OK;
        p[0] = it.pos_x;
        p[1] = it.pos_y;
        p[2] = it.pos_z;
        if (!it.present || !in_box(p[0], box_x) || !in_box(p[1], box_y) ||
            !in_box(p[2], box_z)) return STAT_WORKSPACE;
        if (it.timestamp_ns == 0) return STAT_ZERO_TIME;
        if (!trk_flags[l][0]) begin
            // First pose of a limb: nothing to compare against, so only stage it.
            for (int a = 0; a < 3; a++) begin
                stg_pos[l*3+a] = p[a];
                stg_vel[l*3+a] = 0;
            end
            stg_time[l]  = it.timestamp_ns;
            stg_flags[l] = 3'd3;
            return STAT_OK;
        end
        if (it.timestamp_ns <= trk_time[l]) return STAT_TIME_BACK;
        dt = it.timestamp_ns - trk_time[l];

        sum = '0;
        for (int a = 0; a < 3; a++) begin
            d   = p[a] - trk_pos[l*3+a];
            mg  = (d < 0) ? -d : d;
            sum = sum + {64'd0, mg} * {64'd0, mg};
        end
        if (sum > {96'd0, lim_step} * {96'd0, lim_step}) return STAT_STEP;

        // Velocity per axis truncates toward zero and saturates to the signed velocity width.
        sum = '0;
        for (int a = 0; a < 3; a++) begin
            d  = p[a] - trk_pos[l*3+a];
            mg = (d < 0) ? -d : d;
            q  = mg * 64'(NS_PER_S) / dt;
            if (d < 0) begin
                if (q > VEL_LIMIT) q = VEL_LIMIT;
                v[a] = -longint'(q);
            end else begin
                if (q > VEL_LIMIT - 1) q = VEL_LIMIT - 1;
                v[a] = longint'(q);
            end
            sum = sum + {64'd0, q} * {64'd0, q};
        end
        if (sum > {88'd0, lim_speed} * {88'd0, lim_speed}) return STAT_SPEED;

        if (trk_flags[l][1]) begin
            sum = '0;
            for (int a = 0; a < 3; a++) begin
                pv  = trk_vel[l*3+a];
                mg  = (v[a] >= pv) ? v[a] - pv : pv - v[a];
                qa  = ({64'd0, mg} * 128'(NS_PER_S)) / {64'd0, dt};
                am  = (qa > {64'd0, ACC_LIMIT}) ? ACC_LIMIT : qa[63:0];
                sum = sum + {64'd0, am} * {64'd0, am};
            end
            if (sum > {88'd0, lim_accel} * {88'd0, lim_accel}) return STAT_ACCEL;
        end

        for (int a = 0; a < 3; a++) begin
            stg_pos[l*3+a] = p[a];
            stg_vel[l*3+a] = v[a];
        end
        stg_time[l]  = it.timestamp_ns;
        stg_flags[l] = 3'd7;
        return STAT_OK;
    endfunction

    // Advances the shadow state by one accepted item; returns 1 when a verdict is due.
    function automatic bit predict_verdict(t_pose_item it, output t_verdict vd);
        t_status st;
        vd = '0;
        if (it.kind == KIND_CLEAR) begin
            for (int l = 0; l < 3; l++)
                if (it.clear_mask[l]) wipe_limb(l);
            open_frame();
            return 1'b0;
        end
        if (it.limb == LIMB_NONE) return 1'b0;
        if (it.limb == LIMB_RIGHT) open_frame();
        if (frm_status == STAT_OK) begin
            st = judge_pose(it.limb, it);
            if (st != STAT_OK) begin
                frm_status = st;
                frm_limb   = it.limb;
            end
        end
        if (it.limb != LIMB_HEAD) return 1'b0;
        vd.status = frm_status;
        vd.limb   = (frm_status == STAT_OK) ? LIMB_NONE : frm_limb;
        if (frm_status == STAT_OK) begin
            // The whole frame passed, so every staged limb becomes its new history.
            for (int l = 0; l < 3; l++) begin
                if (!stg_flags[l][0]) continue;
                for (int a = 0; a < 3; a++) begin
                    trk_pos[l*3+a] = stg_pos[l*3+a];
                    trk_vel[l*3+a] = stg_vel[l*3+a];
                end
                trk_time[l]  = stg_time[l];
                trk_flags[l] = stg_flags[l][2:1];
            end
        end
        open_frame();
        return 1'b1;
    endfunction

    // Offers one item, waits for the transfer and files the verdict it causes.
    // The sender works in bursts; a gap follows each burst.
    task automatic send_item(t_pose_item it, bit typed = 1'b0, t_verdict typed_vd = '0);
        t_verdict vd;
        bit       due;
        drv        <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        due = predict_verdict(it, vd);
        if (due) verdicts_due.push_back(typed ? typed_vd : vd);
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
        end
    endtask

    // Waits until every verdict is in, then lets a pose with no verdict finish.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (1500) @(posedge i_clk);
    endtask

    task automatic write_limits(logic [63:0] vals[6]);
        for (int i = 0; i < 6; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= REG_INDEX[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        box_x     = vals[0];
        box_y     = vals[1];
        box_z     = vals[2];
        lim_step  = vals[3][31:0];
        lim_speed = vals[4][39:0];
        lim_accel = vals[5][39:0];
    endtask

    function automatic t_pose_item pose(logic [1:0] l, bit pv, bit pr, int x, int y, int z,
                                        logic [63:0] t);
        t_pose_item it;
        it = '0;
        it.limb         = l;
        it.pose_valid   = pv;
        it.present      = pr;
        it.pos_x        = x;
        it.pos_y        = y;
        it.pos_z        = z;
        it.timestamp_ns = t;
        return it;
    endfunction

    function automatic t_pose_item clear_item(logic [2:0] mask);
        t_pose_item it;
        it = '0;
        it.kind       = KIND_CLEAR;
        it.clear_mask = mask;
        return it;
    endfunction

    function automatic void add_row(t_pose_item it, bit typed = 1'b0, t_status st = STAT_OK,
                                    logic [1:0] l = LIMB_NONE);
        t_stim_row r;
        r.is_cfg  = 1'b0;
        r.item    = it;
        r.typed   = typed;
        r.verdict = '{st, l};
        stim_table.push_back(r);
    endfunction

    function automatic void add_cfg_row(logic [63:0] v[6]);
        t_stim_row r;
        r.is_cfg = 1'b1;
        r.cfg    = v;
        stim_table.push_back(r);
    endfunction

    function automatic int jitter(int sc);
        return int'($urandom_range(0, 2 * sc)) - sc;
    endfunction

    // One frame of poses that follows each limb's committed history, with occasional
    // dropped limbs, restarts, ignored items and bad timestamps mixed in.
    task automatic send_frame(int sc, bit broken);
        t_pose_item it;
        int         r;
        for (int l = 0; l < 3; l++)
            if (trk_time[l] > t_now) t_now = trk_time[l];
        if (t_now > 64'hFFFF_FFFF_0000_0000) begin
            send_item(clear_item(3'b111));
            t_now = 64'd1000;
        end
        t_now += $urandom_range(100000, 20000000);
        for (int l = 0; l < 3; l++) begin
            if (broken && $urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 1)) send_item(pose(LIMB_NONE, 1, 1, 0, 0, 0, t_now));
                continue;
            end
            it = pose(l, $urandom_range(0, 19) != 0, $urandom_range(0, 49) != 0,
                      trk_pos[l*3] + jitter(sc), trk_pos[l*3+1] + jitter(sc),
                      trk_pos[l*3+2] + jitter(sc), t_now);
            r = $urandom_range(0, 99);
            if (r < 2) it.timestamp_ns = 0;
            else if (r < 4) it.timestamp_ns = trk_time[l];
            else if (r < 7) it.pos_x = it.pos_x + 32'sd4000000;
            send_item(it);
            if (broken && l == 0 && $urandom_range(0, 1)) send_item(it);
        end
    endtask

    // Receiver: stalls on one of four patterns picked at random, holds off for a long
    // stretch on request, and checks each result transfer against the oldest verdict.
    initial begin
        int       mode;
        int       hold;
        int       tick;
        t_verdict want;
        i_out_stall = 1'b0;
        mode = 0;
        hold = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (verdicts_due.size() == 0) begin
                    $error("result transfer with no verdict due: status %0d limb %0d",
                           o_status, o_failed_limb);
                    fail_count++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_failed_limb !== want.limb) begin
                        $error("failed_limb: expected %0d, got %0d", want.limb,
                               o_failed_limb);
                        fail_count++;
                    end
                end
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold = 5000;
            end
            tick++;
            if (tick % 256 == 0) mode = $urandom_range(0, 3);
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 2) == 0);
                    2: i_out_stall <= tick[0];
                    default: i_out_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    initial begin
        logic [63:0] lims[6];
        t_pose_item  it;
        int          sc, quota, sent, r;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        drv         = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        box_x = '0;
        box_y = '0;
        box_z = '0;
        lim_step  = '0;
        lim_speed = '0;
        lim_accel = '0;
        for (int l = 0; l < 3; l++) wipe_limb(l);
        for (int k = 0; k < 9; k++) begin
            stg_pos[k] = 0;
            stg_vel[k] = 0;
        end
        for (int l = 0; l < 3; l++) stg_time[l] = '0;
        open_frame();
        t_now = 64'd1000;

        // Directed table. After reset the box collapses to the single point at the origin
        // and all motion limits are zero.
        add_row(pose(0, 1, 1, 0, 0, 0, 1));
        add_row(pose(1, 0, 1, 5, 5, 5, 1));
        add_row(pose(2, 1, 0, 0, 0, 0, 1), 1, STAT_WORKSPACE, 2);
        add_row(pose(0, 1, 1, 1, 0, 0, 5));
        add_row(pose(1, 1, 0, -7, 3, 9, 0));
        add_row(pose(2, 1, 1, 0, 0, 0, 5), 1, STAT_WORKSPACE, 0);
        add_row(pose(0, 1, 1, 0, 0, 0, 0));
        add_row(pose(2, 0, 1, 0, 0, 0, 0), 1, STAT_ZERO_TIME, 0);
        add_row(pose(0, 1, 1, 0, 0, 0, 10));
        add_row(pose(1, 1, 1, 0, 0, 0, 10));
        add_row(pose(2, 1, 1, 0, 0, 0, 10), 1, STAT_OK, LIMB_NONE);
        add_row(pose(0, 1, 1, 0, 0, 0, 10));
        add_row(pose(2, 0, 1, 0, 0, 0, 10), 1, STAT_TIME_BACK, 0);
        add_row(pose(LIMB_NONE, 1, 1, 0, 0, 0, 15));
        add_row(pose(0, 1, 1, 0, 0, 0, 20));
        add_row(pose(1, 1, 1, 0, 0, 0, 20));
        add_row(pose(2, 1, 1, 0, 0, 0, 20), 1, STAT_OK, LIMB_NONE);
        // Widest box and limits; upper data bits beyond each limit's width are ignored.
        lims = '{FULL_BOX, FULL_BOX, FULL_BOX, ALL_ONES, ALL_ONES, ALL_ONES};
        add_cfg_row(lims);
        add_row(pose(1, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 30));
        add_row(pose(2, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, ALL_ONES));
        add_row(clear_item(3'b111));
        add_row(pose(0, 1, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, ALL_ONES));
        add_row(pose(0, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ALL_ONES));
        add_row(pose(2, 0, 0, 0, 0, 0, 1));
        add_row(clear_item(3'b000));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[i]) begin
            if (stim_table[i].is_cfg) begin
                drain();
                write_limits(stim_table[i].cfg);
            end else begin
                send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].verdict);
            end
        end

        // Random phases, each with its own box and limits, starting from cleared histories.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            if (ph == 0) begin
                lims = '{FULL_BOX, FULL_BOX, FULL_BOX, ALL_ONES, ALL_ONES, ALL_ONES};
            end else if (ph == 5) begin
                lims = '{FULL_BOX, FULL_BOX, FULL_BOX, 64'd0, 64'd0, 64'd0};
            end else begin
                for (int a = 0; a < 3; a++) begin
                    r = $urandom_range(1000, 2000000);
                    lims[a] = {32'(r + jitter(500)), 32'(-r)};
                end
                lims[3] = {$urandom, 32'($urandom_range(500, 8000))};
                lims[4] = 64'($urandom_range(100000, 2000000000));
                lims[5] = (64'($urandom_range(1000000, 2000000000)) *
                           $urandom_range(1, 500)) & 64'hFF_FFFF_FFFF;
            end
            write_limits(lims);
            if (ph == 1) hold_off_req = 1'b1;
            send_item(clear_item(3'b111));
            t_now = (ph == 3) ? {1'b1, 31'($urandom), 32'($urandom)} : 64'($urandom);
            sc = (lim_step > 40000) ? 20000 : int'(lim_step / 2) + 1;
            quota = (ph == 5) ? 120 : 260;
            sent = 0;
            while (sent < quota) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    it = '0;
                    it.kind         = $urandom;
                    it.limb         = $urandom;
                    it.pose_valid   = $urandom;
                    it.present      = $urandom;
                    it.pos_x        = $urandom;
                    it.pos_y        = $urandom;
                    it.pos_z        = $urandom;
                    it.timestamp_ns = {$urandom, $urandom};
                    it.clear_mask   = $urandom;
                    send_item(it);
                    sent++;
                end else if (r < 9) begin
                    send_item(clear_item($urandom));
                    sent++;
                end else begin
                    send_frame(sc, r < 15);
                    sent += 3;
                end
            end
        end

        drain();
        if (verdicts_due.size() != 0) begin
            $error("%0d verdicts never arrived", verdicts_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== pose_motion_limit_checker.f =====
+incdir+sv
sv/pml_pkg.sv
sv/pml_alu.sv
sv/pose_motion_limit_checker.sv
tb/testbench.sv
